### design/salc_pkg.sv
// ---------------------------------------------------------------------------
// salc_pkg: shared types and constants
// Payload structs, configuration indexes and geometry of the cache.
// ---------------------------------------------------------------------------
package salc_pkg;

  localparam int MaxSets       = 16;
  localparam int MaxWays       = 4;
  localparam int MaxBlockBytes = 16;
  localparam int MemBytes      = 4096;
  localparam int NumLines      = MaxSets * MaxWays;
  localparam int SetW          = $clog2(MaxSets);
  localparam int WayW          = $clog2(MaxWays);
  localparam int OffW          = $clog2(MaxBlockBytes);
  localparam int LineW         = $clog2(NumLines);
  localparam int MemAw         = $clog2(MemBytes);
  localparam int LbAw          = LineW + OffW;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_TAG_W    = 2'd1;
  localparam logic [1:0] REG_OFF_BITS = 2'd2;
  localparam logic [1:0] REG_WAYS     = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
    logic [1:0] way_used;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;      // latch item, decode address
    logic mem_wr_in;  // write input byte to backing memory at item address
    logic tag_eval;   // register victim / hit selection
    logic fill_rd;    // issue backing read for fill byte
    logic fill_wr;    // write returned byte into line
    logic upd;        // update tag, valid, count
    logic fin_rd;     // issue line-byte read
    logic fin_wr;     // write data into line and memory
    logic res_load;   // capture result
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       hit;
    logic       fill_last;
  } sts_t;

endpackage

### design/salc_ram.sv
// ---------------------------------------------------------------------------
// salc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module salc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### design/salc_datapath.sv
// ---------------------------------------------------------------------------
// salc_datapath: cache datapath
// Configuration, tag store, counts, line and backing memories.
// ---------------------------------------------------------------------------
module salc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data,
  input  salc_pkg::in_item_t  item,
  input  salc_pkg::cmd_t      cmd,
  output salc_pkg::sts_t      sts,
  output salc_pkg::out_item_t result
);

  logic [2:0] set_bits, off_bits, ways;
  logic [3:0] tag_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits <= 3'd2;
      tag_w    <= 4'd8;
      off_bits <= 3'd2;
      ways     <= 3'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        salc_pkg::REG_SET_BITS: set_bits <= cfg_data[2:0];
        salc_pkg::REG_TAG_W:    tag_w    <= cfg_data;
        salc_pkg::REG_OFF_BITS: off_bits <= cfg_data[2:0];
        salc_pkg::REG_WAYS:     ways     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [1:0]  act;
  logic [11:0] addr;
  logic [7:0]  wdat;
  logic [11:0] tag;
  logic [salc_pkg::SetW-1:0] set_q;
  logic [salc_pkg::OffW-1:0] off;
  logic [salc_pkg::OffW-1:0] fcnt;
  logic [salc_pkg::OffW-1:0] bmask;
  logic [11:0] base;
  logic        hit;
  logic [salc_pkg::WayW-1:0] way;

  logic [2:0] s_eff, b_eff;
  logic [3:0] t_eff;
  logic [2:0] e_eff;

  always_comb begin
    s_eff = (set_bits > 3'(salc_pkg::SetW)) ? 3'(salc_pkg::SetW) : set_bits;
    b_eff = (off_bits > 3'(salc_pkg::OffW)) ? 3'(salc_pkg::OffW) : off_bits;
    t_eff = (tag_w > 4'd12) ? 4'd12 : tag_w;
    e_eff = (ways == 3'd0) ? 3'd1 :
            (ways > 3'(salc_pkg::MaxWays)) ? 3'(salc_pkg::MaxWays) : ways;
  end

  // Tag store, valid bits and counts in flip-flops, one entry per set.
  logic [salc_pkg::MaxWays-1:0]       valid_q [salc_pkg::MaxSets];
  logic [salc_pkg::MaxWays-1:0][7:0]  cnt_q   [salc_pkg::MaxSets];
  logic [salc_pkg::MaxWays-1:0][11:0] tag_q   [salc_pkg::MaxSets];

  logic [salc_pkg::LineW-1:0] line;
  assign line = {set_q, way};

  // Way selection: first invalid or matching way, else least count.
  logic                      sel_found, sel_hit;
  logic [salc_pkg::WayW-1:0] sel_way, min_way;
  logic [7:0]                min_cnt;
  always_comb begin
    sel_found = 1'b0;
    sel_hit   = 1'b0;
    sel_way   = '0;
    min_way   = '0;
    min_cnt   = cnt_q[set_q][0];
    for (int w = 0; w < salc_pkg::MaxWays; w++) begin
      if (w < int'(e_eff)) begin
        if (!sel_found) begin
          if (!valid_q[set_q][w]) begin
            sel_found = 1'b1;
            sel_way   = salc_pkg::WayW'(w);
          end else if (tag_q[set_q][w] == tag) begin
            sel_found = 1'b1;
            sel_hit   = 1'b1;
            sel_way   = salc_pkg::WayW'(w);
          end
        end
        if (cnt_q[set_q][w] < min_cnt) begin
          min_cnt = cnt_q[set_q][w];
          min_way = salc_pkg::WayW'(w);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act  <= item.action;
      addr <= item.address;
      wdat <= item.write_data;
      tag  <= (item.address >> (4'(b_eff) + 4'(s_eff))) & ((12'd1 << t_eff) - 12'd1);
      set_q <= salc_pkg::SetW'((item.address >> b_eff) &
               ((12'd1 << s_eff) - 12'd1));
      bmask <= salc_pkg::OffW'((5'd1 << b_eff) - 5'd1);
      off   <= salc_pkg::OffW'(item.address & 12'((5'd1 << b_eff) - 5'd1));
      base  <= item.address & ~12'((5'd1 << b_eff) - 5'd1);
      fcnt  <= '0;
    end
    if (cmd.tag_eval) begin
      hit <= sel_hit;
      way <= sel_found ? sel_way : min_way;
    end
    if (cmd.fill_wr) begin
      fcnt <= fcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < salc_pkg::MaxSets; i++) begin
        valid_q[i] <= '0;
        cnt_q[i]   <= '0;
        tag_q[i]   <= '0;
      end
    end else if (cmd.upd) begin
      if (hit) begin
        if (act == salc_pkg::ACT_READ) begin
          if (cnt_q[set_q][way] != 8'hFF) cnt_q[set_q][way] <= cnt_q[set_q][way] + 8'd1;
        end else begin
          cnt_q[set_q][way] <= 8'd1;
        end
      end else begin
        valid_q[set_q][way] <= 1'b1;
        tag_q[set_q][way]   <= tag;
        cnt_q[set_q][way]   <= 8'd1;
      end
    end
  end

  // Backing memory: fill read data is registered and trails its address.
  logic                        mem_we;
  logic [salc_pkg::MemAw-1:0]  mem_a;
  logic [7:0]                  mem_wd, mem_rd;
  always_comb begin
    mem_we = cmd.mem_wr_in || cmd.fin_wr;
    mem_wd = cmd.mem_wr_in ? item.write_data : wdat;
    if (cmd.mem_wr_in) mem_a = item.address;
    else if (cmd.fin_wr) mem_a = addr;
    else mem_a = base | {8'd0, cmd.fill_wr ? fcnt + 1'b1 : fcnt};
  end

  salc_ram #(.Width(8), .Depth(salc_pkg::MemBytes)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wd), .rdata(mem_rd)
  );

  logic                       lb_we;
  logic [salc_pkg::LbAw-1:0]  lb_a;
  logic [7:0]                 lb_wd, lb_rd;
  always_comb begin
    lb_we = cmd.fill_wr || cmd.fin_wr;
    lb_wd = cmd.fill_wr ? mem_rd : wdat;
    lb_a  = {line, cmd.fill_wr ? fcnt : off};
  end

  salc_ram #(.Width(8), .Depth(salc_pkg::NumLines * salc_pkg::MaxBlockBytes)) u_lines (
    .clk(clk), .we(lb_we), .addr(lb_a), .wdata(lb_wd), .rdata(lb_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.hit      <= (act == salc_pkg::ACT_LOAD || act == salc_pkg::ACT_NONE) ? 1'b0 : hit;
      result.way_used <= (act == salc_pkg::ACT_LOAD || act == salc_pkg::ACT_NONE) ? 2'd0 : 2'(way);
      case (act)
        salc_pkg::ACT_LOAD, salc_pkg::ACT_WRITE: result.read_data <= wdat;
        salc_pkg::ACT_READ: result.read_data <= lb_rd;
        default: result.read_data <= 8'd0;
      endcase
    end
  end

  assign sts.action    = act;
  assign sts.hit       = hit;
  assign sts.fill_last = (fcnt == bmask);

endmodule

### design/salc_ctrl.sv
// ---------------------------------------------------------------------------
// salc_ctrl: cache controller
// Sequences decode, lookup, update, fill, line access and result hand-off.
// ---------------------------------------------------------------------------
module salc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [1:0]     in_action,
  input  salc_pkg::sts_t sts,
  output salc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_FILL, S_UPD, S_RD, S_RES, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_OUT && out_ready);

  always_comb begin
    logic take;
    take = in_valid && in_ready;
    cmd = '0;
    cmd.start     = take;
    cmd.mem_wr_in = take && (in_action == salc_pkg::ACT_LOAD);
    cmd.tag_eval  = (state == S_LOOK);
    cmd.fill_wr   = (state == S_FILL);
    cmd.fill_rd   = (state == S_FILL);
    cmd.upd       = (state == S_UPD);
    cmd.fin_wr    = (state == S_RD) && (sts.action == salc_pkg::ACT_WRITE);
    cmd.fin_rd    = (state == S_RD);
    cmd.res_load  = (state == S_RES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE, S_OUT: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (in_valid && in_ready) begin
            state <= (in_action == salc_pkg::ACT_READ ||
                      in_action == salc_pkg::ACT_WRITE) ? S_LOOK : S_RES;
          end else if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        S_LOOK: state <= S_UPD;
        S_UPD:  state <= sts.hit ? S_RD : S_FILL;
        S_FILL: if (sts.fill_last) state <= S_RD;
        S_RD:   state <= S_RES;
        S_RES: begin
          state     <= S_OUT;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT || state == S_IDLE || state == S_LOOK ||
                   state == S_RES)) else $error("result shown outside hand-off");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.tag_eval, cmd.fill_wr, cmd.upd, cmd.fin_rd, cmd.res_load}))
    else $error("overlapping commands");
  a_res_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid) else $error("result not presented");

endmodule

### design/set_associative_lfu_cache_unit.sv
// ---------------------------------------------------------------------------
// set_associative_lfu_cache_unit: LFU set-associative write-through cache
// Byte cache with least-frequently-used replacement over a backing memory.
// ---------------------------------------------------------------------------
// Channel   Signals                       Payload
// in        in_valid / in_ready           in_item_t (action, address, write_data)
// out       out_valid / out_ready         out_item_t (read_data, hit, way_used)
// cfg       cfg_we, cfg_index, cfg_data   register write, no handshake
//
// A load or unused action goes straight to the result; a hit passes through the
// lookup, the count update and the registered line-memory read.
// A miss adds a block fill of 1 to 16 bytes after the count update.
// A new item is taken in the cycle its predecessor's result transfers.
// Reset clears the tag store at once; no clearing pass is needed.
module set_associative_lfu_cache_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  salc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output salc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [3:0]          cfg_data
);

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;

  salc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .in_action(in_data.action), .sts(sts), .cmd(cmd)
  );

  salc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .item(in_data), .cmd(cmd), .sts(sts),
    .result(out_data)
  );

endmodule
